// ----- sv/stable_sorted_priority_queue_macros.svh -----
// assertion macros used by the priority queue rtl
`ifndef STABLE_SORTED_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, disabled during reset
`define SSPQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define SSPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/sspq_pkg.sv -----
// shared types and codes of the sorted priority queue
package sspq_pkg;

   // request kinds carried on tuser
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // operation broadcast to every cell
   typedef struct packed {
      logic ins;
      logic rem;
   } sspq_op_type;

endpackage

// ----- sv/sspq_cell.sv -----
// one slot of the sorted chain: holds a key and payload, shifts with its neighbors
module sspq_cell
   import sspq_pkg::*;
#(
   parameter int KEY_WIDTH     = 16,
   parameter int PAYLOAD_WIDTH = 16,
   parameter int CNT_W         = 5,
   parameter int IDX           = 0
) (
   input  logic                     clock,
   input  sspq_op_type              op,
   input  logic [CNT_W-1:0]         count,
   input  logic [KEY_WIDTH-1:0]     new_key,
   input  logic [PAYLOAD_WIDTH-1:0] new_pay,
   input  logic [KEY_WIDTH-1:0]     left_key,
   input  logic [PAYLOAD_WIDTH-1:0] left_pay,
   input  logic                     left_keep,
   input  logic [KEY_WIDTH-1:0]     right_key,
   input  logic [PAYLOAD_WIDTH-1:0] right_pay,
   output logic [KEY_WIDTH-1:0]     slot_key,
   output logic [PAYLOAD_WIDTH-1:0] slot_pay,
   output logic                     keep,
   output logic [CNT_W-1:0]         pos_term
);

   logic [KEY_WIDTH-1:0]     key_ff, key_in;
   logic [PAYLOAD_WIDTH-1:0] pay_ff, pay_in;
   logic                     boundary;

   // occupied and not greater than the new key: stays in place on insert
   assign keep     = (CNT_W'(IDX) < count) && (key_ff <= new_key);
   // first cell that does not keep is where the new entry lands
   assign boundary = !keep && left_keep;
   assign pos_term = boundary ? CNT_W'(IDX) : '0;

   assign slot_key = key_ff;
   assign slot_pay = pay_ff;

   // next slot contents
   always_comb begin
      key_in = key_ff;
      pay_in = pay_ff;
      if (op.ins) begin
         if (!keep) begin
            if (left_keep) begin
               key_in = new_key;
               pay_in = new_pay;
            end else begin
               key_in = left_key;
               pay_in = left_pay;
            end
         end
      end else if (op.rem) begin
         key_in = right_key;
         pay_in = right_pay;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      pay_ff <= pay_in;
   end

endmodule

// ----- sv/stable_sorted_priority_queue.sv -----
// Sorted priority queue built as a chain of slot cells. Every cell compares
// its key with the incoming key at once, so an insert or a remove is applied
// on the edge that takes its request, and one request beat is taken per cycle;
// the result sits in an output register and a new request is taken whenever
// that register is empty or being drained in the same cycle. Equal keys leave
// in arrival order. Inserting into a full queue and removing from an empty one
// leave the contents unchanged and are flagged in the result status. No clearing
// is needed after reset: only the entry count is reset.
module stable_sorted_priority_queue
   import sspq_pkg::*;
#(
   parameter int CAPACITY      = 16,
   parameter int KEY_WIDTH     = 16,
   parameter int PAYLOAD_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // prio_key, payload_tag
   input  logic [((KEY_WIDTH+PAYLOAD_WIDTH+7)/8)*8-1:0] req_tdata,
   // req_type
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // insert_pos, removed_key, removed_payload, head_valid, head_key,
   // head_payload, entry_count
   output logic [((2*$clog2(CAPACITY+1)+1+2*KEY_WIDTH+2*PAYLOAD_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // status
   output logic [1:0] rsp_tuser
);

`include "stable_sorted_priority_queue_macros.svh"

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int IN_W   = KEY_WIDTH + PAYLOAD_WIDTH;
   localparam int OUT_W  = 2 * CNT_W + 1 + 2 * KEY_WIDTH + 2 * PAYLOAD_WIDTH;
   localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

   logic                     req_acc;
   logic [KEY_WIDTH-1:0]     new_key;
   logic [PAYLOAD_WIDTH-1:0] new_pay;
   logic                     full, empty;
   sspq_op_type              op;

   logic [CNT_W-1:0] count_ff, count_in;

   logic [KEY_WIDTH-1:0]     key_w [CAPACITY];
   logic [PAYLOAD_WIDTH-1:0] pay_w [CAPACITY];
   logic [CAPACITY-1:0]      keep_w;
   logic [CNT_W-1:0]         pos_w [CAPACITY];
   logic [CNT_W-1:0]         pos;

   logic [KEY_WIDTH-1:0]     head_key;
   logic [PAYLOAD_WIDTH-1:0] head_pay;

   logic                     rsp_valid_ff;
   logic [1:0]               rsp_status_ff;
   logic [CNT_W-1:0]         rsp_pos_ff;
   logic [KEY_WIDTH-1:0]     rsp_rkey_ff;
   logic [PAYLOAD_WIDTH-1:0] rsp_rpay_ff;
   logic                     rsp_hval_ff;
   logic [KEY_WIDTH-1:0]     rsp_hkey_ff;
   logic [PAYLOAD_WIDTH-1:0] rsp_hpay_ff;
   logic [CNT_W-1:0]         rsp_count_ff;

   // request beat handshake
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_acc    = req_tvalid && req_tready;
   assign new_key    = req_tdata[KEY_WIDTH-1:0];
   assign new_pay    = req_tdata[IN_W-1:KEY_WIDTH];

   assign full   = (count_ff == CNT_W'(CAPACITY));
   assign empty  = (count_ff == '0);
   assign op.ins = req_acc && (req_tuser == REQ_INSERT) && !full;
   assign op.rem = req_acc && (req_tuser == REQ_REMOVE) && !empty;

   // chain of slot cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [KEY_WIDTH-1:0]     lk, rk;
      logic [PAYLOAD_WIDTH-1:0] lp, rp;
      logic                     lkeep;
      if (i == 0) begin : g_first
         assign lk    = '0;
         assign lp    = '0;
         assign lkeep = 1'b1;
      end else begin : g_mid
         assign lk    = key_w[i-1];
         assign lp    = pay_w[i-1];
         assign lkeep = keep_w[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign rk = '0;
         assign rp = '0;
      end else begin : g_inner
         assign rk = key_w[i+1];
         assign rp = pay_w[i+1];
      end
      sspq_cell #(
         .KEY_WIDTH    (KEY_WIDTH),
         .PAYLOAD_WIDTH(PAYLOAD_WIDTH),
         .CNT_W        (CNT_W),
         .IDX          (i)
      ) u_cell (
         .clock    (clock),
         .op       (op),
         .count    (count_ff),
         .new_key  (new_key),
         .new_pay  (new_pay),
         .left_key (lk),
         .left_pay (lp),
         .left_keep(lkeep),
         .right_key(rk),
         .right_pay(rp),
         .slot_key (key_w[i]),
         .slot_pay (pay_w[i]),
         .keep     (keep_w[i]),
         .pos_term (pos_w[i])
      );
   end

   // insert position from the one cell that marks the boundary
   always_comb begin
      pos = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         pos = pos | pos_w[i];
      end
   end

   // head as it stands after this beat
   always_comb begin
      head_key = key_w[0];
      head_pay = pay_w[0];
      if (op.rem) begin
         head_key = key_w[1];
         head_pay = pay_w[1];
      end else if (op.ins && !keep_w[0]) begin
         head_key = new_key;
         head_pay = new_pay;
      end
   end

   // entry count
   always_comb begin
      count_in = count_ff;
      if (op.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (op.rem) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_acc) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      if (req_acc) begin
         if (req_tuser == REQ_INSERT) begin
            rsp_status_ff <= full ? ST_FULL : ST_OK;
         end else begin
            rsp_status_ff <= empty ? ST_EMPTY : ST_OK;
         end
         rsp_pos_ff   <= op.ins ? pos : '0;
         rsp_rkey_ff  <= op.rem ? key_w[0] : '0;
         rsp_rpay_ff  <= op.rem ? pay_w[0] : '0;
         rsp_hval_ff  <= (count_in != '0);
         rsp_hkey_ff  <= (count_in != '0) ? head_key : '0;
         rsp_hpay_ff  <= (count_in != '0) ? head_pay : '0;
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = OUT_TW'({rsp_count_ff, rsp_hpay_ff, rsp_hkey_ff, rsp_hval_ff,
                                rsp_rpay_ff, rsp_rkey_ff, rsp_pos_ff});

   // checks
   `SSPQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY),
      "entry count above capacity")
   `SSPQ_ASSERT_NEXT(a_rsp_after_req, clock, reset, req_acc, rsp_valid_ff,
      "accepted request beat left no result")
   `SSPQ_ASSERT_NEXT(a_ins_count, clock, reset, op.ins,
      count_ff == $past(count_ff) + CNT_W'(1), "insert did not grow the count")
   `SSPQ_ASSERT_NEXT(a_rsp_count, clock, reset, req_acc, rsp_count_ff == count_ff,
      "reported entry count differs from the stored count")

endmodule

// ----- sim/stable_sorted_priority_queue_tb.sv -----
// self-checking testbench of the sorted priority queue: directed table, then random beats
`timescale 1ns / 100ps

module stable_sorted_priority_queue_tb
   import sspq_pkg::*;
();

   localparam int CAPACITY      = 16;
   localparam int KEY_WIDTH     = 16;
   localparam int PAYLOAD_WIDTH = 16;
   localparam int REQ_W         = 32;
   localparam int RSP_W         = 80;
   localparam int RANDOM_BEATS  = 1850;
   localparam int CALM_BEATS    = 200;

   // one result beat: tuser status above the tdata fields
   typedef struct packed {
      logic [1:0]               status;
      logic [4:0]               entry_count;
      logic [PAYLOAD_WIDTH-1:0] head_payload;
      logic [KEY_WIDTH-1:0]     head_key;
      logic                     head_valid;
      logic [PAYLOAD_WIDTH-1:0] removed_payload;
      logic [KEY_WIDTH-1:0]     removed_key;
      logic [4:0]               insert_pos;
   } result_type;

   // one row of the directed table
   typedef struct {
      logic                     kind;
      logic [KEY_WIDTH-1:0]     key;
      logic [PAYLOAD_WIDTH-1:0] tag;
      bit                       typed;
      result_type               want;
   } dir_row_type;

   logic             clock;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;   // prio_key, payload_tag
   logic             req_tuser  = REQ_INSERT;   // req_type
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   // insert_pos, removed_key, removed_payload, head_valid, head_key,
   // head_payload, entry_count
   logic [RSP_W-1:0] rsp_tdata;
   logic [1:0]       rsp_tuser;   // status

   // shadow copy of the sorted entries
   logic [KEY_WIDTH-1:0]     shadow_key [CAPACITY];
   logic [PAYLOAD_WIDTH-1:0] shadow_tag [CAPACITY];
   int                       shadow_fill = 0;

   result_type  pending_rsp [$];
   dir_row_type dir_rows [$];

   int fail_count   = 0;
   int insert_count = 0;
   int remove_count = 0;
   int full_drops   = 0;
   int empty_pops   = 0;
   int peak_fill    = 0;
   int rsp_seen     = 0;

   bit send_idles = 1'b1;
   bit recv_idles = 1'b1;
   bit calm_tail  = 1'b0;
   int stall_left = 0;

   stable_sorted_priority_queue #(
      .CAPACITY      (CAPACITY),
      .KEY_WIDTH     (KEY_WIDTH),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // apply one request to the shadow queue and return the result it gives
   function automatic result_type queue_apply(input logic kind,
                                              input logic [KEY_WIDTH-1:0] key,
                                              input logic [PAYLOAD_WIDTH-1:0] tag);
      result_type r;
      int         pos;
      r = '0;
      r.status = ST_OK;
      if (kind == REQ_INSERT) begin
         insert_count++;
         if (shadow_fill >= CAPACITY) begin
            r.status = ST_FULL;
            full_drops++;
         end else begin
            // stable: go past every entry with a key less than or equal
            pos = 0;
            while (pos < shadow_fill && shadow_key[pos] <= key)
               pos++;
            for (int i = shadow_fill; i > pos; i--) begin
               shadow_key[i] = shadow_key[i-1];
               shadow_tag[i] = shadow_tag[i-1];
            end
            shadow_key[pos] = key;
            shadow_tag[pos] = tag;
            shadow_fill++;
            r.insert_pos = pos[4:0];
         end
      end else begin
         remove_count++;
         if (shadow_fill == 0) begin
            r.status = ST_EMPTY;
            empty_pops++;
         end else begin
            r.removed_key     = shadow_key[0];
            r.removed_payload = shadow_tag[0];
            for (int i = 1; i < shadow_fill; i++) begin
               shadow_key[i-1] = shadow_key[i];
               shadow_tag[i-1] = shadow_tag[i];
            end
            shadow_fill--;
         end
      end
      if (shadow_fill > peak_fill)
         peak_fill = shadow_fill;
      if (shadow_fill > 0) begin
         r.head_valid   = 1'b1;
         r.head_key     = shadow_key[0];
         r.head_payload = shadow_tag[0];
      end
      r.entry_count = shadow_fill[4:0];
      return r;
   endfunction

   // push a table row; typed rows carry the result read off by hand
   task automatic add_row(input logic kind, input logic [15:0] key, input logic [15:0] tag,
                          input bit typed, input logic [1:0] status, input logic [4:0] pos,
                          input logic [15:0] head_key, input logic [15:0] head_tag,
                          input logic [4:0] count);
      dir_row_type row;
      row.kind = kind;
      row.key  = key;
      row.tag  = tag;
      row.typed = typed;
      row.want = '0;
      row.want.status       = status;
      row.want.insert_pos   = pos;
      row.want.head_valid   = (count != 0);
      row.want.head_key     = head_key;
      row.want.head_payload = head_tag;
      row.want.entry_count  = count;
      dir_rows.push_back(row);
   endtask

   // offer one request beat, wait for it to be taken, queue its expected result
   task automatic send_beat(input logic kind, input logic [15:0] key, input logic [15:0] tag,
                            input bit typed, input result_type typed_want);
      result_type predicted;
      if (send_idles && !calm_tail && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {tag, key};
      do @(posedge clock); while (!req_tready);
      predicted = queue_apply(kind, key, tag);
      pending_rsp.push_back(typed ? typed_want : predicted);
   endtask

   task automatic compare_field(input string what, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
         fail_count++;
      end
   endtask

   // result side backpressure in bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (recv_idles && !calm_tail && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 13);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // check each result beat against the oldest expectation
   always @(posedge clock) begin : rsp_check
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tdata[74:0]};
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            $display("%0t: result beat with no request pending, actual %h", $time, got);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            compare_field("status",          16'(want.status),      16'(got.status));
            compare_field("insert_pos",      16'(want.insert_pos),  16'(got.insert_pos));
            compare_field("removed_key",     want.removed_key,      got.removed_key);
            compare_field("removed_payload", want.removed_payload,  got.removed_payload);
            compare_field("head_valid",      16'(want.head_valid),  16'(got.head_valid));
            compare_field("head_key",        want.head_key,         got.head_key);
            compare_field("head_payload",    want.head_payload,     got.head_payload);
            compare_field("entry_count",     16'(want.entry_count), 16'(got.entry_count));
         end
      end
   end

   // stimulus: directed table, then random phases
   initial begin : stimulus
      int               ins_pct;
      logic             kind;
      logic [15:0]      key;
      logic [15:0]      tag;
      dir_row_type      row;

      // empty remove, extremes, equal keys, fill to full, drop on full
      add_row(REQ_REMOVE, 16'h0000, 16'h0000, 1'b1, ST_EMPTY, 5'd0, 16'h0000, 16'h0000, 5'd0);
      add_row(REQ_INSERT, 16'hffff, 16'h0000, 1'b1, ST_OK,    5'd0, 16'hffff, 16'h0000, 5'd1);
      add_row(REQ_INSERT, 16'h0000, 16'hffff, 1'b1, ST_OK,    5'd0, 16'h0000, 16'hffff, 5'd2);
      add_row(REQ_INSERT, 16'h8000, 16'h1111, 1'b0, ST_OK, 5'd0, 16'h0, 16'h0, 5'd0);
      add_row(REQ_INSERT, 16'h8000, 16'h2222, 1'b0, ST_OK, 5'd0, 16'h0, 16'h0, 5'd0);
      add_row(REQ_INSERT, 16'hffff, 16'h3333, 1'b0, ST_OK, 5'd0, 16'h0, 16'h0, 5'd0);
      add_row(REQ_INSERT, 16'h0000, 16'h4444, 1'b0, ST_OK, 5'd0, 16'h0, 16'h0, 5'd0);
      add_row(REQ_REMOVE, 16'h5a5a, 16'ha5a5, 1'b0, ST_OK, 5'd0, 16'h0, 16'h0, 5'd0);
      add_row(REQ_REMOVE, 16'hffff, 16'hffff, 1'b0, ST_OK, 5'd0, 16'h0, 16'h0, 5'd0);
      for (int k = 0; k < 12; k++)
         add_row(REQ_INSERT, 16'(16'h1000 * k), 16'(16'ha5a5 ^ k), 1'b0, ST_OK, 5'd0,
                 16'h0, 16'h0, 5'd0);
      add_row(REQ_INSERT, 16'h0001, 16'h7777, 1'b1, ST_FULL, 5'd0, 16'h0000, 16'ha5a5, 5'd16);
      add_row(REQ_REMOVE, 16'h0000, 16'h0000, 1'b0, ST_OK, 5'd0, 16'h0, 16'h0, 5'd0);
      add_row(REQ_INSERT, 16'h0000, 16'h0000, 1'b0, ST_OK, 5'd0, 16'h0, 16'h0, 5'd0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         send_beat(row.kind, row.key, row.tag, row.typed, row.want);
      end

      // random phases with a drifting insert share so the queue swings full and empty
      ins_pct = 50;
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(0, 3))
               0: ins_pct = 10;
               1: ins_pct = 40;
               2: ins_pct = 60;
               default: ins_pct = 90;
            endcase
            send_idles = ($urandom_range(0, 3) != 0);
            recv_idles = ($urandom_range(0, 3) != 0);
         end
         if (n == RANDOM_BEATS - CALM_BEATS)
            calm_tail = 1'b1;
         kind = ($urandom_range(0, 99) < ins_pct) ? REQ_INSERT : REQ_REMOVE;
         case ($urandom_range(0, 3))
            0: key = 16'($urandom_range(0, 7));
            1: key = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
            default: key = 16'($urandom_range(0, 16'hffff));
         endcase
         tag = 16'($urandom_range(0, 16'hffff));
         send_beat(kind, key, tag, 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      // drain, then idle to catch any stray beat
      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);

      $display("covered %0d inserts (%0d dropped on full) and %0d removes (%0d on empty)",
               insert_count, full_drops, remove_count, empty_pops);
      $display("%0d result beats checked, queue depth reached %0d of %0d",
               rsp_seen, peak_fill, CAPACITY);
      if (fail_count == 0)
         $display("[stable_sorted_priority_queue] OK");
      else
         $display("[stable_sorted_priority_queue] ERROR");
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("[stable_sorted_priority_queue] ERROR");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/sspq_pkg.sv
sv/sspq_cell.sv
sv/stable_sorted_priority_queue.sv
sim/stable_sorted_priority_queue_tb.sv
